### rtl/sh_pkg.sv
package sh_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

  localparam logic [63:0] SIP_FIN_NARROW = 64'h00000000000000ff;
  localparam logic [63:0] SIP_FIN_WIDE   = 64'h00000000000000ee;
  localparam logic [63:0] SIP_FIN_SECOND = 64'h00000000000000dd;

  localparam logic [3:0] SH_FULL_BYTES = 4'd8;
  localparam int SH_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CFG_KEY_LOW     = 2'd0,
    CFG_KEY_HIGH    = 2'd1,
    CFG_WIDE_OUTPUT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic        wide_output;
  } sh_cfg_t;

  typedef enum logic [1:0] {
    KIND_WORD      = 2'd0,
    KIND_LAST_FULL = 2'd1,
    KIND_LAST_TAIL = 2'd2
  } sh_kind_t;

  typedef struct packed {
    logic [63:0] word;
    logic [63:0] final_block;
    sh_kind_t    kind;
  } sh_entry_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_COMP1 = 3'd1,
    BK_COMP2 = 3'd2,
    BK_FIN   = 3'd3,
    BK_DONE  = 3'd4
  } bk_state_t;

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = {r.v1[50:0], r.v1[63:51]};
    r.v1 = r.v1 ^ r.v0;
    r.v0 = {r.v0[31:0], r.v0[63:32]};
    r.v2 = r.v2 + r.v3;
    r.v3 = {r.v3[47:0], r.v3[63:48]};
    r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = {r.v3[42:0], r.v3[63:43]};
    r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = {r.v1[46:0], r.v1[63:47]};
    r.v1 = r.v1 ^ r.v2;
    r.v2 = {r.v2[31:0], r.v2[63:32]};
    return r;
  endfunction

endpackage

### rtl/sh_front.sv
module sh_front import sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  output logic        push,
  input  logic        queue_ready,
  output sh_entry_t   entry
);

  logic [7:0]  length_count;
  logic [7:0]  length_count_next;
  logic [3:0]  count;
  logic [7:0]  length_sum;
  logic [63:0] tail;

  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready;

  always_comb begin
    count = (byte_count > SH_FULL_BYTES) ? SH_FULL_BYTES : byte_count;
    for (int i = 0; i < 8; i++) begin
      tail[i*8 +: 8] = (4'(i) < count) ? message_word[i*8 +: 8] : 8'h00;
    end
    if (count == SH_FULL_BYTES) begin
      tail = '0;
    end
    length_sum = length_count + {4'd0, count};
  end

  always_comb begin
    entry.word        = message_word;
    entry.final_block = {length_sum, tail[55:0]};
    if (!last_word) begin
      entry.kind = KIND_WORD;
    end else if (count == SH_FULL_BYTES) begin
      entry.kind = KIND_LAST_FULL;
    end else begin
      entry.kind = KIND_LAST_TAIL;
    end
    length_count_next = last_word ? 8'd0 : length_count + {4'd0, SH_FULL_BYTES};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count <= 8'd0;
    end else if (push) begin
      length_count <= length_count_next;
    end
  end

endmodule

### rtl/sh_queue.sv
module sh_queue import sh_pkg::*; #(
  parameter int Depth = SH_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sh_entry_t push_entry,
  output logic      ready,
  input  logic      pop,
  output logic      head_valid,
  output sh_entry_t head_entry
);

  localparam int PtrWidth   = $clog2(Depth);
  localparam int CountWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

  sh_entry_t             slots [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CountWidth-1:0] count;
  logic                  do_pop;

  assign ready      = count != FullCount;
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue empty with unequal pointers");

endmodule

### rtl/sh_back.sv
module sh_back import sh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sh_cfg_t      cfg,
  input  logic         head_valid,
  input  sh_entry_t    head_entry,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_low,
  output logic [63:0]  out_high
);

  bk_state_t   state;
  bk_state_t   state_next;
  sip_state_t  v;
  sip_state_t  v_next;
  logic        open;
  logic        open_next;
  logic [1:0]  rnd;
  logic [1:0]  rnd_next;
  logic        second_pass;
  logic        second_pass_next;
  logic        tail_done;
  logic        tail_done_next;
  logic [63:0] cur_m;
  logic [63:0] cur_m_next;
  logic [63:0] cur_final;
  logic [63:0] cur_final_next;
  sh_kind_t    cur_kind;
  sh_kind_t    cur_kind_next;
  logic [63:0] h1;
  logic [63:0] h1_next;
  logic [63:0] h2;
  logic [63:0] h2_next;
  logic        out_free;
  logic        out_load;

  sip_state_t  key_state;
  sip_state_t  base;
  sip_state_t  round_in;
  sip_state_t  round_out;
  logic [63:0] first_m;
  logic [63:0] round_xor;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == BK_IDLE) && head_valid;
  assign out_load = (state == BK_DONE) && out_free;

  always_comb begin
    key_state.v0 = SIP_C0 ^ cfg.key_low;
    key_state.v1 = SIP_C1 ^ cfg.key_high ^ (cfg.wide_output ? SIP_FIN_WIDE : 64'd0);
    key_state.v2 = SIP_C2 ^ cfg.key_low;
    key_state.v3 = SIP_C3 ^ cfg.key_high;
    base    = open ? v : key_state;
    first_m = (head_entry.kind == KIND_LAST_TAIL) ? head_entry.final_block
                                                  : head_entry.word;
    round_in = v;
    if (state == BK_IDLE) begin
      round_in    = base;
      round_in.v3 = base.v3 ^ first_m;
    end else if (state == BK_COMP1) begin
      round_in.v3 = v.v3 ^ cur_m;
    end
    round_out = sip_round(round_in);
    round_xor = round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = BK_COMP2;
        end
      end
      BK_COMP1: state_next = BK_COMP2;
      BK_COMP2: begin
        if (cur_kind == KIND_WORD) begin
          state_next = BK_IDLE;
        end else if (!tail_done) begin
          state_next = BK_COMP1;
        end else begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (rnd == 2'd3 && (second_pass || !cfg.wide_output)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    v_next           = v;
    open_next        = open;
    rnd_next         = rnd;
    second_pass_next = second_pass;
    tail_done_next   = tail_done;
    cur_m_next       = cur_m;
    cur_final_next   = cur_final;
    cur_kind_next    = cur_kind;
    h1_next          = h1;
    h2_next          = h2;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          v_next         = round_out;
          open_next      = 1'b1;
          cur_m_next     = first_m;
          cur_final_next = head_entry.final_block;
          cur_kind_next  = head_entry.kind;
          tail_done_next = head_entry.kind == KIND_LAST_TAIL;
        end
      end
      BK_COMP1: v_next = round_out;
      BK_COMP2: begin
        v_next    = round_out;
        v_next.v0 = round_out.v0 ^ cur_m;
        if (cur_kind != KIND_WORD) begin
          if (!tail_done) begin
            cur_m_next     = cur_final;
            tail_done_next = 1'b1;
          end else begin
            v_next.v2 = round_out.v2 ^ (cfg.wide_output ? SIP_FIN_WIDE : SIP_FIN_NARROW);
            rnd_next         = 2'd0;
            second_pass_next = 1'b0;
          end
        end
      end
      BK_FIN: begin
        v_next   = round_out;
        rnd_next = rnd + 2'd1;
        if (rnd == 2'd3) begin
          if (!second_pass) begin
            h1_next = round_xor;
            h2_next = '0;
            if (cfg.wide_output) begin
              v_next.v1        = round_out.v1 ^ SIP_FIN_SECOND;
              second_pass_next = 1'b1;
            end
          end else begin
            h2_next = round_xor;
          end
        end
      end
      BK_DONE: begin
        if (out_free) begin
          open_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      open      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      open  <= open_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    v           <= v_next;
    rnd         <= rnd_next;
    second_pass <= second_pass_next;
    tail_done   <= tail_done_next;
    cur_m       <= cur_m_next;
    cur_final   <= cur_final_next;
    cur_kind    <= cur_kind_next;
    h1          <= h1_next;
    h2          <= h2_next;
    if (out_load) begin
      out_low  <= h1;
      out_high <= h2;
    end
  end

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("finished hash not presented");

  a_busy_open: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> open)
    else $error("engine busy without an open message");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == BK_COMP2))
    else $error("entry taken without starting compression");

endmodule

### rtl/siphash_2_4_stream_hasher_unit.sv
// A word that is not the last takes two SipRounds in the round engine, one SipRound per cycle.
// A last word takes two (short tail) or four (full word) SipRounds, then four or eight
// finalisation rounds and a hand-over state (BK_DONE) before the hash is presented, plus queueing.
// Words are hashed one at a time in the single shared round unit; the queue accepts words until full.
// Reset (rst, synchronous) clears the key registers, the length count, the queue and the
// output valid flag; the next word then opens a message from the key.
module siphash_2_4_stream_hasher_unit import sh_pkg::*; #(
  parameter int QueueDepth = SH_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,  // message_word [63:0], byte_count [67:64], zero fill
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // hash_low [63:0], hash_high [127:64]
);

  sh_cfg_t     cfg;
  logic        push;
  logic        queue_ready;
  sh_entry_t   push_entry;
  logic        head_valid;
  sh_entry_t   head_entry;
  logic        pop;
  logic [63:0] hash_low;
  logic [63:0] hash_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LOW:     cfg.key_low     <= cfg_data;
        CFG_KEY_HIGH:    cfg.key_high    <= cfg_data;
        CFG_WIDE_OUTPUT: cfg.wide_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .message_word (s_tdata[63:0]),
    .byte_count   (s_tdata[67:64]),
    .last_word    (s_tlast),
    .push         (push),
    .queue_ready  (queue_ready),
    .entry        (push_entry)
  );

  sh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  sh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_low    (hash_low),
    .out_high   (hash_high)
  );

  assign m_tdata = {hash_high, hash_low};

endmodule

### verif/siphash_2_4_stream_hasher_unit_tb.sv
module siphash_2_4_stream_hasher_unit_tb;
  import sh_pkg::*;

  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic [63:0] hash_high;
    logic [63:0] hash_low;
  } digest_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;  // message_word [63:0], byte_count [67:64], zero fill
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;  // hash_low [63:0], hash_high [127:64]

  logic [63:0] cfg_k0;
  logic [63:0] cfg_k1;
  logic        cfg_wide;
  lanes_t      lanes;
  logic [7:0]  msg_len;
  logic        msg_open;

  digest_t digest_q[$];
  int      mismatches;
  int      hashes_checked;
  int      words_sent;
  int      configs_used;
  bit      gaps_on;
  bit      hold_request;

  siphash_2_4_stream_hasher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("siphash_2_4_stream_hasher_unit: mismatch");
    $finish;
  end

  function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic lanes_t sip_mix(input lanes_t s);
    s.v0 = s.v0 + s.v1; s.v1 = rol64(s.v1, 13); s.v1 = s.v1 ^ s.v0; s.v0 = rol64(s.v0, 32);
    s.v2 = s.v2 + s.v3; s.v3 = rol64(s.v3, 16); s.v3 = s.v3 ^ s.v2;
    s.v0 = s.v0 + s.v3; s.v3 = rol64(s.v3, 21); s.v3 = s.v3 ^ s.v0;
    s.v2 = s.v2 + s.v1; s.v1 = rol64(s.v1, 17); s.v1 = s.v1 ^ s.v2; s.v2 = rol64(s.v2, 32);
    return s;
  endfunction

  function automatic lanes_t absorb_block(input lanes_t s, input logic [63:0] m);
    s.v3 = s.v3 ^ m;
    s = sip_mix(sip_mix(s));
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

  function automatic lanes_t mix_four(input lanes_t s);
    return sip_mix(sip_mix(sip_mix(sip_mix(s))));
  endfunction

  task automatic predict_word(input logic [63:0] word, input logic [3:0] cnt,
                              input logic last);
    logic [3:0]  n;
    logic [63:0] blk;
    digest_t     d;
    if (!msg_open) begin
      lanes.v0 = SIP_C0 ^ cfg_k0;
      lanes.v1 = SIP_C1 ^ cfg_k1 ^ (cfg_wide ? SIP_FIN_WIDE : 64'd0);
      lanes.v2 = SIP_C2 ^ cfg_k0;
      lanes.v3 = SIP_C3 ^ cfg_k1;
      msg_len  = 8'd0;
      msg_open = 1'b1;
    end
    if (!last) begin
      lanes   = absorb_block(lanes, word);
      msg_len = msg_len + 8'd8;
    end else begin
      n = (cnt > SH_FULL_BYTES) ? SH_FULL_BYTES : cnt;
      if (n == SH_FULL_BYTES) begin
        lanes   = absorb_block(lanes, word);
        msg_len = msg_len + 8'd8;
        blk     = 64'd0;
      end else begin
        blk     = (n == 4'd0) ? 64'd0 : (word & ((64'd1 << (8 * n)) - 64'd1));
        msg_len = msg_len + n;
      end
      blk[63:56] = msg_len;
      lanes      = absorb_block(lanes, blk);
      lanes.v2   = lanes.v2 ^ (cfg_wide ? SIP_FIN_WIDE : SIP_FIN_NARROW);
      lanes      = mix_four(lanes);
      d.hash_low  = lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3;
      d.hash_high = 64'd0;
      if (cfg_wide) begin
        lanes.v1    = lanes.v1 ^ SIP_FIN_SECOND;
        lanes       = mix_four(lanes);
        d.hash_high = lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3;
      end
      digest_q.push_back(d);
      msg_open = 1'b0;
    end
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_word(input logic [63:0] word, input logic [3:0] cnt, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, cnt, word};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(word, cnt, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_KEY_LOW:     cfg_k0 = val;
      CFG_KEY_HIGH:    cfg_k1 = val;
      CFG_WIDE_OUTPUT: cfg_wide = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [63:0] k0, input logic [63:0] k1, input logic w);
    drain();
    write_reg(CFG_KEY_LOW, k0);
    write_reg(CFG_KEY_HIGH, k1);
    write_reg(CFG_WIDE_OUTPUT, {63'd0, w});
    configs_used++;
  endtask

  task automatic test_reset_defaults();
    push_word(64'd0, 4'd0, 1'b1);
    push_word('1, SH_FULL_BYTES, 1'b1);
  endtask

  task automatic test_reference_vector();
    set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 1'b0);
    push_word(64'h0706050403020100, SH_FULL_BYTES, 1'b0);
    push_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
    set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 1'b1);
    push_word(64'h0706050403020100, SH_FULL_BYTES, 1'b0);
    push_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
  endtask

  task automatic test_tail_lengths();
    int c;
    set_config('1, 64'd0, 1'b0);
    for (c = 0; c < 8; c++) push_word('1, 4'(c), 1'b1);
    push_word(rand_word(), SH_FULL_BYTES, 1'b1);
    push_word({$urandom, $urandom}, 4'd9, 1'b1);
    push_word('1, 4'd15, 1'b1);
    // Short words that are not last still count as eight bytes.
    push_word({$urandom, $urandom}, 4'd3, 1'b0);
    push_word({$urandom, $urandom}, 4'd0, 1'b0);
    push_word({$urandom, $urandom}, 4'd5, 1'b1);
  endtask

  task automatic test_midstream_config();
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, SH_FULL_BYTES, 1'b0);
    drain();
    write_reg(CFG_WIDE_OUTPUT, 64'd1);
    write_reg(CFG_KEY_LOW, {$urandom, $urandom});
    push_word({$urandom, $urandom}, 4'd4, 1'b1);
    push_word({$urandom, $urandom}, SH_FULL_BYTES, 1'b0);
    drain();
    write_reg(CFG_WIDE_OUTPUT, 64'd0);
    write_reg(CFG_KEY_HIGH, '1);
    push_word({$urandom, $urandom}, SH_FULL_BYTES, 1'b1);
    configs_used++;
  endtask

  task automatic random_message();
    int          n_full;
    int          i;
    logic [3:0]  cnt;
    n_full = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
    for (i = 0; i < n_full; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : SH_FULL_BYTES;
      push_word(rand_word(), cnt, 1'b0);
    end
    cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    push_word(rand_word(), cnt, 1'b1);
  endtask

  task automatic test_back_pressure();
    int i;
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    hold_request = 1'b1;
    for (i = 0; i < 8; i++) push_word(rand_word(), 4'($urandom_range(0, 8)), 1'b1);
    drain();
    for (i = 0; i < 6; i++) random_message();
  endtask

  task automatic test_random_messages();
    int phase;
    int stop_at;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config('1, '1, 1'b1);
        1: set_config(64'd0, 64'd0, 1'b0);
        default: set_config({$urandom, $urandom},
                            ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom},
                            1'($urandom_range(0, 1)));
      endcase
      gaps_on = (phase != 5);
      stop_at = words_sent + 115;
      while (words_sent < stop_at) random_message();
    end
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    digest_t d;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        d = digest_q.pop_front();
        if (m_tdata[63:0] !== d.hash_low) begin
          $display("%0t: hash_low expected %h actual %h", $time, d.hash_low, m_tdata[63:0]);
          mismatches++;
        end
        if (m_tdata[127:64] !== d.hash_high) begin
          $display("%0t: hash_high expected %h actual %h", $time, d.hash_high,
                   m_tdata[127:64]);
          mismatches++;
        end
      end
      hashes_checked++;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_KEY_LOW;
    cfg_data     = 64'd0;
    s_tvalid     = 1'b0;
    s_tdata      = 72'd0;
    s_tlast      = 1'b0;
    cfg_k0       = 64'd0;
    cfg_k1       = 64'd0;
    cfg_wide     = 1'b0;
    msg_open     = 1'b0;
    msg_len      = 8'd0;
    lanes        = '0;
    mismatches   = 0;
    hashes_checked = 0;
    words_sent   = 0;
    configs_used = 1;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_reference_vector();
    test_tail_lengths();
    test_midstream_config();
    test_back_pressure();
    test_random_messages();
    drain();

    $display("Sent %0d words and checked %0d hashes under %0d key and width settings,",
             words_sent, hashes_checked, configs_used);
    $display("covering tails of 0 to 15 bytes, length wrap, mid-message changes and stalls.");
    if (mismatches == 0) begin
      $display("siphash_2_4_stream_hasher_unit: match");
    end else begin
      $display("siphash_2_4_stream_hasher_unit: mismatch");
    end
    $finish;
  end

endmodule
